// ----- hw/rtl/assert_macros.svh -----
// Assertion macros for the checker file xmrx_chk.sv.
// No dependencies; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define XMRX_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("xmrx assertion failed");

// Condition that must never be true on a clock edge outside reset.
`define XMRX_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("xmrx forbidden condition seen");

`endif

// ----- hw/rtl/xmrx_pkg.sv -----
`timescale 1ns / 1ps
// Types, codes and the CRC-16 step for the XMODEM receive deframer.
// No dependencies; used by the top level and its checker.
package xmrx_pkg;

    typedef struct packed {
        logic       opcode;
        logic [7:0] rx_byte;
    } item_t;

    typedef struct packed {
        logic [3:0] event_kind;
        logic [7:0] data_byte;
        logic [6:0] data_index;
        logic [7:0] packet_number;
        logic [7:0] reply_byte;
    } result_t;

    // Input opcodes
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Result event kinds
    localparam logic [3:0] EV_NONE      = 4'd0;
    localparam logic [3:0] EV_DATA      = 4'd1;
    localparam logic [3:0] EV_OK        = 4'd2;
    localparam logic [3:0] EV_BAD_NUM   = 4'd3;
    localparam logic [3:0] EV_BAD_CHECK = 4'd4;
    localparam logic [3:0] EV_EOT       = 4'd5;
    localparam logic [3:0] EV_CAN       = 4'd6;
    localparam logic [3:0] EV_C         = 4'd7;
    localparam logic [3:0] EV_TIMEOUT   = 4'd8;

    // Protocol bytes
    localparam logic [7:0] B_NONE = 8'h00;
    localparam logic [7:0] B_SOH  = 8'h01;
    localparam logic [7:0] B_EOT  = 8'h04;
    localparam logic [7:0] B_ACK  = 8'h06;
    localparam logic [7:0] B_NAK  = 8'h15;
    localparam logic [7:0] B_CAN  = 8'h18;
    localparam logic [7:0] B_C    = 8'h43;

    localparam logic [7:0] NUM_PAIR_SUM = 8'hFF;

    // Configuration port
    localparam int unsigned CFG_INDEX_W = 1;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] REG_CHECK_MODE     = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PACKET_TIMEOUT = 1'd1;

    localparam logic        CHECK_MODE_RESET     = 1'b1;
    localparam logic [15:0] PACKET_TIMEOUT_RESET = 16'd300;

    // CRC-16/XMODEM, poly 0x1021, MSB first, one byte
    function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ 16'h1021;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// ----- hw/rtl/xmodem_packet_receiver_unit.sv -----
`timescale 1ns / 1ps
// XMODEM receive deframer, top level.
// Depends on xmrx_pkg.
//
// Usage:
//   Input channel (item_valid / item_stall / item): one received byte
//   (opcode 0) or one timer tick (opcode 1) per item.
//   Result channel (result_valid / result_stall / result): exactly one
//   result per item, in order; event_kind 0 means nothing to report.
//   Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): index 0
//   is check_mode, index 1 is packet_timeout. cfg_ready is always high;
//   write only while no item is in flight.
// Registers: an accepted item passes the input register, then the result
//   register, which drives the ports (two register stages).
// Throughput: one item per cycle while result_stall holds no full result
//   register; CRC/sum update and timer decrement fit the single stage.
// Reset: parser idle, timer stopped, check_mode = CRC, packet_timeout = 300,
//   both channels empty.
// Stall: when result_stall holds a full result register, the processing
//   stage waits and item_stall rises once the input register is also full.
module xmodem_packet_receiver_unit #(
    parameter int unsigned PAYLOAD_BYTES = 128,
    parameter int unsigned TIMER_BITS    = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   item_valid,
    output logic                                   item_stall,
    input  xmrx_pkg::item_t                        item,
    output logic                                   result_valid,
    input  logic                                   result_stall,
    output xmrx_pkg::result_t                      result,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [xmrx_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [xmrx_pkg::CFG_DATA_W-1:0]        cfg_data
);

    localparam int unsigned CNT_W = $clog2(PAYLOAD_BYTES);
    localparam int unsigned CMP_W = (TIMER_BITS > 16) ? TIMER_BITS : 16;
    localparam logic [CNT_W-1:0] LAST_INDEX = CNT_W'(PAYLOAD_BYTES - 1);

    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_HEADER = 2'd1;
    localparam logic [1:0] PH_DATA   = 2'd2;
    localparam logic [1:0] PH_CHECK  = 2'd3;

    // configuration
    logic        check_mode_reg;
    logic [15:0] packet_timeout_reg;

    // input register
    logic            item_valid_reg;
    xmrx_pkg::item_t item_reg;

    // parser state
    logic [1:0]            phase_reg, phase_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [7:0]            header_reg, header_next;
    logic [15:0]           check_reg, check_next;
    logic [7:0]            check_high_reg, check_high_next;
    logic [TIMER_BITS-1:0] timer_left_reg, timer_left_next;
    logic                  timer_running_reg, timer_running_next;

    // result register
    logic              result_valid_reg;
    xmrx_pkg::result_t result_reg, result_next;

    logic                  advance;
    logic [TIMER_BITS-1:0] timer_dec;
    logic [TIMER_BITS-1:0] timer_load;
    logic [CMP_W-1:0]      timeout_ext;
    logic [CMP_W-1:0]      timer_max_ext;
    logic [8:0]            pair_sum;
    logic [7:0]            b;

    assign cfg_ready    = 1'b1;
    assign advance      = item_valid_reg && (!result_valid_reg || !result_stall);
    assign item_stall   = item_valid_reg && !advance;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    assign b             = item_reg.rx_byte;
    assign pair_sum      = {1'b0, header_reg} + {1'b0, b};
    assign timeout_ext   = CMP_W'(packet_timeout_reg);
    assign timer_max_ext = CMP_W'({TIMER_BITS{1'b1}});
    assign timer_load    = (timeout_ext > timer_max_ext) ? {TIMER_BITS{1'b1}}
                                                         : timeout_ext[TIMER_BITS-1:0];
    assign timer_dec     = (timer_left_reg != '0) ? timer_left_reg - 1'b1 : timer_left_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            check_mode_reg     <= xmrx_pkg::CHECK_MODE_RESET;
            packet_timeout_reg <= xmrx_pkg::PACKET_TIMEOUT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                xmrx_pkg::REG_CHECK_MODE:     check_mode_reg     <= cfg_data[0];
                xmrx_pkg::REG_PACKET_TIMEOUT: packet_timeout_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        phase_next         = phase_reg;
        count_next         = count_reg;
        header_next        = header_reg;
        check_next         = check_reg;
        check_high_next    = check_high_reg;
        timer_left_next    = timer_left_reg;
        timer_running_next = timer_running_reg;
        result_next        = '0;

        if (item_reg.opcode == xmrx_pkg::OP_TICK)
        begin
            if (timer_running_reg)
            begin
                timer_left_next = timer_dec;
                if (timer_dec == '0)
                begin
                    phase_next                = PH_IDLE;
                    count_next                = '0;
                    timer_running_next        = 1'b0;
                    result_next.event_kind    = xmrx_pkg::EV_TIMEOUT;
                    result_next.reply_byte    = xmrx_pkg::B_NAK;
                end
            end
        end
        else
        begin
            case (phase_reg)
                PH_IDLE:
                begin
                    if (b == xmrx_pkg::B_C)
                        result_next.event_kind = xmrx_pkg::EV_C;
                    else if (b == xmrx_pkg::B_SOH)
                    begin
                        phase_next = PH_HEADER;
                        count_next = '0;
                        if (packet_timeout_reg != 16'd0)
                        begin
                            timer_left_next    = timer_load;
                            timer_running_next = 1'b1;
                        end
                        else
                        begin
                            timer_left_next    = '0;
                            timer_running_next = 1'b0;
                        end
                    end
                    else if (b == xmrx_pkg::B_EOT)
                    begin
                        result_next.event_kind = xmrx_pkg::EV_EOT;
                        result_next.reply_byte = xmrx_pkg::B_ACK;
                    end
                    else if (b == xmrx_pkg::B_CAN)
                        result_next.event_kind = xmrx_pkg::EV_CAN;
                end
                PH_HEADER:
                begin
                    if (count_reg == '0)
                    begin
                        header_next = b;
                        count_next  = CNT_W'(1);
                    end
                    else if (pair_sum == {1'b0, xmrx_pkg::NUM_PAIR_SUM})
                    begin
                        phase_next = PH_DATA;
                        count_next = '0;
                        check_next = '0;
                    end
                    else
                    begin
                        phase_next                = PH_IDLE;
                        count_next                = '0;
                        timer_running_next        = 1'b0;
                        timer_left_next           = '0;
                        result_next.event_kind    = xmrx_pkg::EV_BAD_NUM;
                        result_next.packet_number = header_reg;
                        result_next.reply_byte    = xmrx_pkg::B_NAK;
                    end
                end
                PH_DATA:
                begin
                    if (check_mode_reg)
                        check_next = xmrx_pkg::crc16_step(check_reg, b);
                    else
                        check_next = {8'h00, check_reg[7:0] + b};
                    result_next.event_kind    = xmrx_pkg::EV_DATA;
                    result_next.data_byte     = b;
                    result_next.data_index    = count_reg[6:0];
                    result_next.packet_number = header_reg;
                    if (count_reg == LAST_INDEX)
                    begin
                        phase_next = PH_CHECK;
                        count_next = '0;
                    end
                    else
                        count_next = count_reg + 1'b1;
                end
                PH_CHECK:
                begin
                    if (!check_mode_reg || count_reg != '0)
                    begin
                        // final check byte: sum mode compares low byte, CRC mode the pair
                        phase_next                = PH_IDLE;
                        count_next                = '0;
                        timer_running_next        = 1'b0;
                        timer_left_next           = '0;
                        result_next.packet_number = header_reg;
                        if ((!check_mode_reg && b == check_reg[7:0]) ||
                            (check_mode_reg && {check_high_reg, b} == check_reg))
                        begin
                            result_next.event_kind = xmrx_pkg::EV_OK;
                            result_next.reply_byte = xmrx_pkg::B_ACK;
                        end
                        else
                        begin
                            result_next.event_kind = xmrx_pkg::EV_BAD_CHECK;
                            result_next.reply_byte = xmrx_pkg::B_NAK;
                        end
                    end
                    else
                    begin
                        check_high_next = b;
                        count_next      = CNT_W'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else if (!item_stall)
            item_valid_reg <= item_valid;
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
            item_reg <= item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_IDLE;
            count_reg         <= '0;
            header_reg        <= '0;
            check_reg         <= '0;
            check_high_reg    <= '0;
            timer_left_reg    <= '0;
            timer_running_reg <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg         <= phase_next;
            count_reg         <= count_next;
            header_reg        <= header_next;
            check_reg         <= check_next;
            check_high_reg    <= check_high_next;
            timer_left_reg    <= timer_left_next;
            timer_running_reg <= timer_running_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (advance)
            result_valid_reg <= 1'b1;
        else if (!result_stall)
            result_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            result_reg <= result_next;
    end

endmodule

// ----- hw/rtl/xmrx_chk.sv -----
`timescale 1ns / 1ps
// Port-level checker for the XMODEM receive deframer, bound to the top level.
// Depends on xmrx_pkg and assert_macros.svh.
`include "assert_macros.svh"

module xmrx_chk (
    input logic              clk,
    input logic              rst_n,
    input logic              result_valid,
    input logic              result_stall,
    input xmrx_pkg::result_t result
);

    logic       ack_kind;
    logic       nak_kind;
    logic       quiet_kind;
    logic       data_kind;
    logic       result_held;
    logic       data_fields_set;
    logic [7:0] reply;

    assign ack_kind = (result.event_kind == xmrx_pkg::EV_OK) ||
                      (result.event_kind == xmrx_pkg::EV_EOT);
    assign nak_kind = (result.event_kind == xmrx_pkg::EV_BAD_NUM) ||
                      (result.event_kind == xmrx_pkg::EV_BAD_CHECK) ||
                      (result.event_kind == xmrx_pkg::EV_TIMEOUT);
    assign quiet_kind      = !ack_kind && !nak_kind;
    assign data_kind       = (result.event_kind == xmrx_pkg::EV_DATA);
    assign result_held     = result_valid && result_stall;
    assign data_fields_set = (result.data_byte != 8'd0) || (result.data_index != 7'd0);
    assign reply           = result.reply_byte;

    // a held result stays offered and unchanged
    `XMRX_ASSERT(a_result_held, clk, rst_n, result_held |=> result_valid && $stable(result))
    // reply byte follows the event kind
    `XMRX_ASSERT(a_reply_ack, clk, rst_n, result_valid && ack_kind |-> reply == xmrx_pkg::B_ACK)
    `XMRX_ASSERT(a_reply_nak, clk, rst_n, result_valid && nak_kind |-> reply == xmrx_pkg::B_NAK)
    `XMRX_NEVER(a_reply_stray, clk, rst_n, result_valid && quiet_kind && reply != xmrx_pkg::B_NONE)
    // data item fields only on data items
    `XMRX_NEVER(a_data_stray, clk, rst_n, result_valid && !data_kind && data_fields_set)

endmodule

bind xmodem_packet_receiver_unit xmrx_chk u_xmrx_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the XMODEM receive deframer: directed table, then random traffic.
// Depends on xmrx_pkg and xmodem_packet_receiver_unit; carries its own model of the deframer.
module tb_top;
    import xmrx_pkg::*;

    localparam int PAYLOAD_BYTES = 128;
    localparam int ITEM_TARGET   = 1275;
    localparam int QUIET_TAIL    = 300;
    localparam int LONG_HOLD     = 60;
    localparam int DRAIN_CYCLES  = 4;
    localparam int CYCLE_LIMIT   = 250000;

    typedef enum logic [1:0] {RX_IDLE, RX_HEADER, RX_DATA, RX_CHECK} rx_phase_e;
    typedef enum logic [1:0] {ROW_ITEM, ROW_TYPED, ROW_CFG} row_kind_e;

    typedef struct packed {
        row_kind_e              kind;
        item_t                  stim;
        logic [CFG_INDEX_W-1:0] reg_index;
        logic [CFG_DATA_W-1:0]  reg_value;
        result_t                want;
    } step_row_t;

    logic                   clk          = 1'b0;
    logic                   rst_n        = 1'b0;
    logic                   item_valid   = 1'b0;
    logic                   item_stall;
    item_t                  item         = '0;
    logic                   result_valid;
    logic                   result_stall = 1'b0;
    result_t                result;
    logic                   cfg_valid    = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index    = '0;
    logic [CFG_DATA_W-1:0]  cfg_data     = '0;

    // Deframer model state and its copy of the registers
    logic        crc_mode;
    logic [15:0] pkt_timeout;
    rx_phase_e   rx_phase;
    int          rx_count;
    logic [7:0]  pkt_number;
    logic [15:0] rx_check;
    logic [7:0]  check_hi;
    logic [15:0] timer_left;
    logic        timer_on;

    result_t pending_events[$];
    int      mismatches    = 0;
    int      cycle_count   = 0;
    int      items_sent    = 0;
    int      gap_pct       = 20;
    int      stall_pct     = 20;
    int      hold_requests = 0;
    int      hold_seen     = 0;
    int      hold_left     = 0;
    int      stall_left    = 0;

    xmodem_packet_receiver_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic logic [15:0] crc16_xmodem(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 7; i >= 0; i--)
        begin
            fb = c[15] ^ b[i];
            c  = {c[14:0], 1'b0} ^ (fb ? 16'h1021 : 16'h0000);
        end
        return c;
    endfunction

    function automatic result_t make_result(input logic [3:0] kind, input logic [7:0] data,
                                            input logic [6:0] idx, input logic [7:0] num,
                                            input logic [7:0] reply);
        result_t r;
        r.event_kind    = kind;
        r.data_byte     = data;
        r.data_index    = idx;
        r.packet_number = num;
        r.reply_byte    = reply;
        return r;
    endfunction

    function automatic void drop_packet();
        rx_phase   = RX_IDLE;
        rx_count   = 0;
        timer_on   = 1'b0;
        timer_left = '0;
    endfunction

    // Advance the deframer model by one item and return the event it reports
    function automatic result_t deframe_step(input item_t it);
        result_t    r;
        logic [7:0] b;
        logic [7:0] num;
        r   = make_result(EV_NONE, 8'h00, 7'd0, 8'h00, B_NONE);
        b   = it.rx_byte;
        num = pkt_number;
        if (it.opcode == OP_TICK)
        begin
            if (timer_on)
            begin
                if (timer_left != 0)
                    timer_left--;
                if (timer_left == 0)
                begin
                    drop_packet();
                    r = make_result(EV_TIMEOUT, 8'h00, 7'd0, 8'h00, B_NAK);
                end
            end
            return r;
        end
        case (rx_phase)
            RX_IDLE:
            begin
                if (b == B_C)
                    r.event_kind = EV_C;
                else if (b == B_SOH)
                begin
                    rx_phase   = RX_HEADER;
                    rx_count   = 0;
                    timer_left = pkt_timeout;
                    timer_on   = (pkt_timeout != 0);
                end
                else if (b == B_EOT)
                    r = make_result(EV_EOT, 8'h00, 7'd0, 8'h00, B_ACK);
                else if (b == B_CAN)
                    r.event_kind = EV_CAN;
            end
            RX_HEADER:
            begin
                if (rx_count == 0)
                begin
                    pkt_number = b;
                    rx_count   = 1;
                end
                else if (({1'b0, pkt_number} + {1'b0, b}) == {1'b0, NUM_PAIR_SUM})
                begin
                    rx_phase = RX_DATA;
                    rx_count = 0;
                    rx_check = '0;
                end
                else
                begin
                    drop_packet();
                    r = make_result(EV_BAD_NUM, 8'h00, 7'd0, num, B_NAK);
                end
            end
            RX_DATA:
            begin
                if (crc_mode)
                    rx_check = crc16_xmodem(rx_check, b);
                else
                    rx_check = {8'h00, rx_check[7:0] + b};
                r = make_result(EV_DATA, b, 7'(rx_count), num, B_NONE);
                rx_count++;
                if (rx_count >= PAYLOAD_BYTES)
                begin
                    rx_phase = RX_CHECK;
                    rx_count = 0;
                end
            end
            default:
            begin
                // mode in force now decides how many trailer bytes are taken
                if (!crc_mode)
                begin
                    drop_packet();
                    if (b == rx_check[7:0])
                        r = make_result(EV_OK, 8'h00, 7'd0, num, B_ACK);
                    else
                        r = make_result(EV_BAD_CHECK, 8'h00, 7'd0, num, B_NAK);
                end
                else if (rx_count == 0)
                begin
                    check_hi = b;
                    rx_count = 1;
                end
                else
                begin
                    drop_packet();
                    if ({check_hi, b} == rx_check)
                        r = make_result(EV_OK, 8'h00, 7'd0, num, B_ACK);
                    else
                        r = make_result(EV_BAD_CHECK, 8'h00, 7'd0, num, B_NAK);
                end
            end
        endcase
        return r;
    endfunction

    task automatic send_item(input logic op, input logic [7:0] b, input bit typed,
                             input result_t want);
        item_t   it;
        result_t predicted;
        it.opcode  = op;
        it.rx_byte = b;
        item_valid <= 1'b1;
        item       <= it;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        predicted  = deframe_step(it);
        pending_events.push_back(typed ? want : predicted);
        items_sent++;
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 11))
                @(posedge clk);
        end
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_item(OP_BYTE, b, 1'b0, '0);
    endtask

    task automatic send_tick();
        send_item(OP_TICK, 8'($urandom), 1'b0, '0);
    endtask

    task automatic wait_drained();
        item_valid <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == REG_CHECK_MODE)
            crc_mode = value[0];
        else
            pkt_timeout = value;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_packet();
        logic [7:0]  num;
        logic [7:0]  data;
        logic [15:0] trailer;
        int          pattern;
        int          tick_pct;
        num      = 8'($urandom);
        pattern  = $urandom_range(0, 5);
        tick_pct = $urandom_range(0, 4);
        send_byte(B_SOH);
        send_byte(num);
        send_byte($urandom_range(0, 9) == 0 ? 8'($urandom) : NUM_PAIR_SUM - num);
        for (int i = 0; i < PAYLOAD_BYTES; i++)
        begin
            if ($urandom_range(0, 99) < tick_pct)
                send_tick();
            if ($urandom_range(0, 299) == 0)
            begin
                if ($urandom_range(0, 1) == 1)
                    write_reg(REG_CHECK_MODE, 16'($urandom_range(0, 1)));
                else
                    write_reg(REG_PACKET_TIMEOUT, 16'($urandom_range(0, 400)));
            end
            case (pattern)
                0:       data = 8'h00;
                1:       data = 8'hFF;
                2:       data = 8'(i);
                default: data = 8'($urandom);
            endcase
            send_byte(data);
        end
        trailer = rx_check;
        if ($urandom_range(0, 4) == 0)
            trailer ^= 16'(1 << $urandom_range(0, 15));
        if (crc_mode)
        begin
            send_byte(trailer[15:8]);
            send_byte(trailer[7:0]);
        end
        else
            send_byte(trailer[7:0]);
    endtask

    // Open a packet, send up to 12 bytes, then, if the receive timer runs with at most 400 left, tick until it runs out
    task automatic send_timed_out_packet();
        logic [7:0] num;
        num = 8'($urandom);
        send_byte(B_SOH);
        send_byte(num);
        send_byte(NUM_PAIR_SUM - num);
        repeat ($urandom_range(0, 12))
            send_byte(8'($urandom));
        while (timer_on && timer_left <= 400)
            send_tick();
    endtask

    task automatic send_noise();
        repeat ($urandom_range(1, 6))
        begin
            case ($urandom_range(0, 5))
                0:       send_byte(B_C);
                1:       send_byte(B_EOT);
                2:       send_byte(B_CAN);
                3:       send_tick();
                default: send_byte(8'($urandom));
            endcase
        end
    endtask

    task automatic check_field(input string field, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin : result_side
        result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_events.size() == 0)
            begin
                $error("event_kind: expected no result, got %0d", result.event_kind);
                mismatches++;
            end
            else
            begin
                want = pending_events.pop_front();
                check_field("event_kind", want.event_kind, result.event_kind);
                check_field("data_byte", want.data_byte, result.data_byte);
                check_field("data_index", want.data_index, result.data_index);
                check_field("packet_number", want.packet_number, result.packet_number);
                check_field("reply_byte", want.reply_byte, result.reply_byte);
            end
        end
        if (hold_seen != hold_requests)
        begin
            hold_seen = hold_requests;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            result_stall <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            result_stall <= 1'b1;
        end
        else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct)
        begin
            stall_left = $urandom_range(1, 11) - 1;
            result_stall <= 1'b1;
        end
        else
            result_stall <= 1'b0;
    end

    function automatic step_row_t item_row(input row_kind_e kind, input logic op,
                                           input logic [7:0] b, input result_t want);
        step_row_t row;
        row              = '0;
        row.kind         = kind;
        row.stim.opcode  = op;
        row.stim.rx_byte = b;
        row.want         = want;
        return row;
    endfunction

    function automatic step_row_t cfg_row(input logic [CFG_INDEX_W-1:0] idx,
                                          input logic [15:0] value);
        step_row_t row;
        row           = '0;
        row.kind      = ROW_CFG;
        row.reg_index = idx;
        row.reg_value = value;
        return row;
    endfunction

    initial
    begin : stimulus
        step_row_t   rows[$];
        result_t     none;
        int          episode;
        int          setting_no;
        int          pick;
        bit          quiet;
        logic        mode;
        logic [15:0] timeout;

        crc_mode    = CHECK_MODE_RESET;
        pkt_timeout = PACKET_TIMEOUT_RESET;
        rx_phase    = RX_IDLE;
        rx_count    = 0;
        pkt_number  = '0;
        rx_check    = '0;
        check_hi    = '0;
        timer_left  = '0;
        timer_on    = 1'b0;
        none        = make_result(EV_NONE, 8'h00, 7'd0, 8'h00, B_NONE);
        episode     = 0;
        setting_no  = 0;
        quiet       = 1'b0;

        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        rows.push_back(item_row(ROW_TYPED, OP_TICK, 8'hA5, none));
        rows.push_back(item_row(ROW_TYPED, OP_BYTE, B_C,
                                make_result(EV_C, 8'h00, 7'd0, 8'h00, B_NONE)));
        rows.push_back(item_row(ROW_TYPED, OP_BYTE, B_EOT,
                                make_result(EV_EOT, 8'h00, 7'd0, 8'h00, B_ACK)));
        rows.push_back(item_row(ROW_TYPED, OP_BYTE, B_CAN,
                                make_result(EV_CAN, 8'h00, 7'd0, 8'h00, B_NONE)));
        rows.push_back(item_row(ROW_TYPED, OP_BYTE, 8'hFF, none));
        rows.push_back(item_row(ROW_TYPED, OP_BYTE, 8'h00, none));
        // header whose number and complement do not add up
        rows.push_back(item_row(ROW_ITEM, OP_BYTE, B_SOH, none));
        rows.push_back(item_row(ROW_ITEM, OP_BYTE, 8'h00, none));
        rows.push_back(item_row(ROW_TYPED, OP_BYTE, 8'h00,
                                make_result(EV_BAD_NUM, 8'h00, 7'd0, 8'h00, B_NAK)));
        // timer expires in the data phase
        rows.push_back(cfg_row(REG_PACKET_TIMEOUT, 16'd3));
        rows.push_back(item_row(ROW_ITEM, OP_BYTE, B_SOH, none));
        rows.push_back(item_row(ROW_ITEM, OP_BYTE, 8'hFF, none));
        rows.push_back(item_row(ROW_ITEM, OP_BYTE, 8'h00, none));
        rows.push_back(item_row(ROW_TYPED, OP_BYTE, 8'hFF,
                                make_result(EV_DATA, 8'hFF, 7'd0, 8'hFF, B_NONE)));
        rows.push_back(item_row(ROW_TYPED, OP_BYTE, 8'h00,
                                make_result(EV_DATA, 8'h00, 7'd1, 8'hFF, B_NONE)));
        rows.push_back(item_row(ROW_ITEM, OP_TICK, 8'h5A, none));
        rows.push_back(item_row(ROW_ITEM, OP_TICK, 8'h00, none));
        rows.push_back(item_row(ROW_TYPED, OP_TICK, 8'hFF,
                                make_result(EV_TIMEOUT, 8'h00, 7'd0, 8'h00, B_NAK)));
        rows.push_back(item_row(ROW_TYPED, OP_TICK, 8'h00, none));
        // zero timeout: timer never starts
        rows.push_back(cfg_row(REG_PACKET_TIMEOUT, 16'd0));
        rows.push_back(item_row(ROW_ITEM, OP_BYTE, B_SOH, none));
        rows.push_back(item_row(ROW_ITEM, OP_TICK, 8'h81, none));
        rows.push_back(item_row(ROW_ITEM, OP_BYTE, 8'h80, none));
        rows.push_back(item_row(ROW_TYPED, OP_BYTE, 8'h80,
                                make_result(EV_BAD_NUM, 8'h00, 7'd0, 8'h80, B_NAK)));
        // one-tick timeout hits while still in the header
        rows.push_back(cfg_row(REG_PACKET_TIMEOUT, 16'd1));
        rows.push_back(item_row(ROW_ITEM, OP_BYTE, B_SOH, none));
        rows.push_back(item_row(ROW_TYPED, OP_TICK, 8'h7E,
                                make_result(EV_TIMEOUT, 8'h00, 7'd0, 8'h00, B_NAK)));
        rows.push_back(cfg_row(REG_CHECK_MODE, 16'd0));

        foreach (rows[i])
        begin
            case (rows[i].kind)
                ROW_CFG:   write_reg(rows[i].reg_index, rows[i].reg_value);
                ROW_TYPED: send_item(rows[i].stim.opcode, rows[i].stim.rx_byte, 1'b1,
                                     rows[i].want);
                default:   send_item(rows[i].stim.opcode, rows[i].stim.rx_byte, 1'b0, '0);
            endcase
        end

        while (items_sent < ITEM_TARGET)
        begin
            if (!quiet && items_sent >= ITEM_TARGET - QUIET_TAIL)
            begin
                quiet = 1'b1;
                gap_pct = 0;
                stall_pct <= 0;
            end
            if (episode % 3 == 0)
            begin
                case (setting_no % 5)
                    0:       timeout = 16'($urandom_range(1, 12));
                    1:       timeout = 16'd0;
                    2:       timeout = 16'hFFFF;
                    3:       timeout = PACKET_TIMEOUT_RESET;
                    default: timeout = 16'($urandom_range(13, 65534));
                endcase
                mode = (setting_no < 2) ? setting_no[0] : 1'($urandom_range(0, 1));
                write_reg(REG_CHECK_MODE, {15'($urandom), mode});
                write_reg(REG_PACKET_TIMEOUT, timeout);
                setting_no++;
                if (!quiet)
                begin
                    gap_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
                    stall_pct <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
                end
            end
            pick = $urandom_range(0, 99);
            if (episode == 1)
            begin
                // output held off while items keep coming, so the input backs up
                gap_pct = 0;
                hold_requests <= hold_requests + 1;
                send_packet();
            end
            else if (pick < 60)
                send_packet();
            else if (pick < 80)
                send_noise();
            else
                send_timed_out_packet();
            episode++;
        end

        wait_drained();
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/xmrx_pkg.sv
hw/rtl/xmodem_packet_receiver_unit.sv
hw/rtl/xmrx_chk.sv
verif/tb_top.sv
